FILE: sv/qpsm_pkg.sv
package qpsm_pkg;

  localparam int CHUNK_W = 32;
  localparam int Q_BITS  = 32;
  localparam int CNT_W   = 5;

  // 60000 ms/min scaled by 2^16 (encoder) and 2^8 (tachometer)
  localparam logic [31:0] SCALE_ENC  = 32'd3932160000;
  localparam logic [31:0] SCALE_TACH = 32'd15360000;

  localparam int unsigned MIN_ENC_MS  = 10;
  localparam int unsigned MIN_TACH_MS = 50;

  typedef enum logic [2:0] {
    OP_AB_CHANGE  = 3'd0,
    OP_TACH_PULSE = 3'd1,
    OP_SPEED_REQ  = 3'd2,
    OP_POS_RESET  = 3'd3,
    OP_START      = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    REG_TICKS_PER_REV = 2'd0,
    REG_GEAR_RATIO    = 2'd1,
    REG_FG_PULSES     = 2'd2,
    REG_USE_ENCODER   = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_EVAL,
    CMD_MUL_NUM_SETUP,
    CMD_MUL_STEP,
    CMD_MUL_DEN_SETUP,
    CMD_DIV_SETUP,
    CMD_DIV_STEP,
    CMD_OUT
  } dp_cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DECIDE,
    S_MUL_NUM,
    S_MUL_DEN,
    S_DIV,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic    load;
    dp_cmd_t op;
  } ctl_cmd_t;

  typedef struct packed {
    logic go;
    logic direct;
    logic out_free;
  } dp_status_t;

  // index is {old AB, new AB}
  function automatic logic signed [1:0] quad_step(input logic [3:0] idx);
    logic signed [1:0] s;
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14:  s = 2'sb01;
      4'd2, 4'd4, 4'd11, 4'd13: s = 2'sb11;
      default:                  s = 2'sb00;
    endcase
    return s;
  endfunction

endpackage

FILE: sv/qpsm_ctrl.sv
module qpsm_ctrl #(
  parameter int MUL_CHUNKS = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  qpsm_pkg::dp_status_t  st,
  output qpsm_pkg::ctl_cmd_t    cmd
);

  localparam logic [qpsm_pkg::CNT_W-1:0] MUL_LAST = qpsm_pkg::CNT_W'(MUL_CHUNKS + 1);
  localparam logic [qpsm_pkg::CNT_W-1:0] DIV_LAST = qpsm_pkg::CNT_W'(qpsm_pkg::Q_BITS - 1);

  qpsm_pkg::state_t             state, state_next;
  logic [qpsm_pkg::CNT_W-1:0]   cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= qpsm_pkg::S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd.load   = 1'b0;
    cmd.op     = qpsm_pkg::CMD_NONE;
    in_stall   = 1'b1;
    case (state)
      qpsm_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = qpsm_pkg::S_EVAL;
        end
      end
      qpsm_pkg::S_EVAL: begin
        cmd.op     = qpsm_pkg::CMD_EVAL;
        state_next = qpsm_pkg::S_DECIDE;
      end
      qpsm_pkg::S_DECIDE: begin
        if (st.go && !st.direct) begin
          cmd.op     = qpsm_pkg::CMD_MUL_NUM_SETUP;
          cnt_next   = '0;
          state_next = qpsm_pkg::S_MUL_NUM;
        end else begin
          state_next = qpsm_pkg::S_RESULT;
        end
      end
      qpsm_pkg::S_MUL_NUM: begin
        if (cnt == MUL_LAST) begin
          cmd.op     = qpsm_pkg::CMD_MUL_DEN_SETUP;
          cnt_next   = '0;
          state_next = qpsm_pkg::S_MUL_DEN;
        end else begin
          cmd.op   = qpsm_pkg::CMD_MUL_STEP;
          cnt_next = cnt + 1'b1;
        end
      end
      qpsm_pkg::S_MUL_DEN: begin
        if (cnt == MUL_LAST) begin
          cmd.op     = qpsm_pkg::CMD_DIV_SETUP;
          cnt_next   = '0;
          state_next = qpsm_pkg::S_DIV;
        end else begin
          cmd.op   = qpsm_pkg::CMD_MUL_STEP;
          cnt_next = cnt + 1'b1;
        end
      end
      qpsm_pkg::S_DIV: begin
        cmd.op = qpsm_pkg::CMD_DIV_STEP;
        if (cnt == DIV_LAST) begin
          cnt_next   = '0;
          state_next = qpsm_pkg::S_RESULT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      qpsm_pkg::S_RESULT: begin
        cmd.op = qpsm_pkg::CMD_OUT;
        if (st.out_free) begin
          state_next = qpsm_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = qpsm_pkg::S_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/qpsm_datapath.sv
module qpsm_datapath #(
  parameter int POSITION_WIDTH = 32,
  parameter int TIME_WIDTH     = 32,
  parameter int MUL_CHUNKS     = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [1:0]            cfg_index,
  input  logic [15:0]           cfg_data,
  input  logic [2:0]            op,
  input  logic                  pin_a,
  input  logic                  pin_b,
  input  logic [31:0]           now_ms,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [31:0]    position,
  output logic signed [31:0]    rpm_q8,
  output logic                  rpm_valid,
  input  qpsm_pkg::ctl_cmd_t    cmd,
  output qpsm_pkg::dp_status_t  st
);

  localparam int PW = POSITION_WIDTH;
  localparam int TW = TIME_WIDTH;
  localparam int CW = qpsm_pkg::CHUNK_W;
  localparam int QB = qpsm_pkg::Q_BITS;
  localparam int MW = CW * MUL_CHUNKS;
  localparam int WW = MW + CW;

  // configuration
  logic [15:0]   ticks_per_rev;
  logic [15:0]   gear_ratio_q8;
  logic [7:0]    fg_pulses_per_rev;
  logic          use_encoder_feedback;

  // architectural state
  logic [1:0]    prev_ab;
  logic [PW-1:0] position_count;
  logic [PW-1:0] last_position;
  logic [TW-1:0] last_encoder_time;
  logic [31:0]   tach_count;
  logic [TW-1:0] last_tach_time;

  // accepted transaction
  logic [2:0]    it_op;
  logic [1:0]    it_ab;
  logic [31:0]   it_now;

  // speed request
  logic          rq_go;
  logic          rq_neg;
  logic          rq_zero;
  logic          rq_sat;
  logic [MW-1:0] rq_mag;
  logic [TW-1:0] rq_dt;

  // multiplier and divider
  logic [MW-1:0] ma;
  logic [CW-1:0] mb;
  logic [63:0]   pp;
  logic [WW-1:0] acc;
  logic [WW-1:0] num;
  logic [WW-1:0] den;
  logic [WW-1:0] rem;
  logic [QB-1:0] dq;
  logic          ovf;

  logic [63:0]        now64;
  logic [TW-1:0]      now_t;
  logic [TW-1:0]      dt_enc;
  logic [TW-1:0]      dt_tach;
  logic [PW-1:0]      pos_delta;
  logic [PW-1:0]      mag_enc;
  logic               go;
  logic signed [1:0]  step;
  logic [PW-1:0]      step_ext;
  logic [MW-1:0]      mag_sel;
  logic               unit_zero;
  logic [31:0]        unit_enc;
  logic [CW-1:0]      ma_top;
  logic [WW-1:0]      num_hi;
  logic [WW:0]        rem2;
  logic [WW:0]        den_ext;
  logic [WW:0]        diff;
  logic               ge;
  logic [31:0]        limit;
  logic [31:0]        qv;
  logic [31:0]        v;
  logic [31:0]        rpm_res;
  logic [63:0]        pos64;
  logic               out_load;

  assign now64     = 64'(it_now);
  assign now_t     = now64[TW-1:0];
  assign dt_enc    = now_t - last_encoder_time;
  assign dt_tach   = now_t - last_tach_time;
  assign pos_delta = position_count - last_position;
  assign mag_enc   = pos_delta[PW-1] ? (~pos_delta + 1'b1) : pos_delta;
  assign go        = (it_op == qpsm_pkg::OP_SPEED_REQ) &&
                     (use_encoder_feedback ? (dt_enc >= TW'(qpsm_pkg::MIN_ENC_MS))
                                           : (dt_tach >= TW'(qpsm_pkg::MIN_TACH_MS)));
  assign step      = qpsm_pkg::quad_step({prev_ab, it_ab});
  assign step_ext  = {{(PW-2){step[1]}}, step};
  assign mag_sel   = use_encoder_feedback ? MW'(mag_enc) : MW'(tach_count);
  assign unit_zero = use_encoder_feedback ? (ticks_per_rev == '0 || gear_ratio_q8 == '0)
                                          : (fg_pulses_per_rev == '0);
  assign unit_enc  = 32'(ticks_per_rev) * 32'(gear_ratio_q8);

  assign ma_top  = ma[MW-1 -: CW];
  assign num_hi  = WW'(num[WW-1:CW]);
  assign rem2    = {rem, dq[QB-1]};
  assign den_ext = {1'b0, den};
  assign ge      = rem2 >= den_ext;
  assign diff    = rem2 - den_ext;

  assign limit   = rq_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
  assign qv      = (ovf || dq > limit) ? limit : dq;
  assign v       = (!rq_go || rq_zero) ? 32'd0 : (rq_sat ? limit : qv);
  assign rpm_res = rq_neg ? (~v + 1'b1) : v;

  assign pos64    = 64'(position_count);
  assign st.go       = rq_go;
  assign st.direct   = rq_zero | rq_sat;
  assign st.out_free = !out_valid || !out_stall;
  assign out_load    = (cmd.op == qpsm_pkg::CMD_OUT) && st.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_rev        <= 16'd100;
      gear_ratio_q8        <= 16'd256;
      fg_pulses_per_rev    <= 8'd6;
      use_encoder_feedback <= 1'b1;
      prev_ab              <= '0;
      position_count       <= '0;
      last_position        <= '0;
      last_encoder_time    <= '0;
      tach_count           <= '0;
      last_tach_time       <= '0;
      out_valid            <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          qpsm_pkg::REG_TICKS_PER_REV: ticks_per_rev        <= cfg_data;
          qpsm_pkg::REG_GEAR_RATIO:    gear_ratio_q8        <= cfg_data;
          qpsm_pkg::REG_FG_PULSES:     fg_pulses_per_rev    <= cfg_data[7:0];
          qpsm_pkg::REG_USE_ENCODER:   use_encoder_feedback <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.op == qpsm_pkg::CMD_EVAL) begin
        case (it_op)
          qpsm_pkg::OP_AB_CHANGE: begin
            position_count <= position_count + step_ext;
            prev_ab        <= it_ab;
          end
          qpsm_pkg::OP_TACH_PULSE: begin
            tach_count <= tach_count + 1'b1;
          end
          qpsm_pkg::OP_SPEED_REQ: begin
            if (go) begin
              if (use_encoder_feedback) begin
                last_position     <= position_count;
                last_encoder_time <= now_t;
              end else begin
                tach_count     <= '0;
                last_tach_time <= now_t;
              end
            end
          end
          qpsm_pkg::OP_POS_RESET: begin
            position_count <= '0;
            last_position  <= '0;
          end
          qpsm_pkg::OP_START: begin
            prev_ab           <= it_ab;
            position_count    <= '0;
            last_position     <= '0;
            tach_count        <= '0;
            last_encoder_time <= now_t;
            last_tach_time    <= now_t;
          end
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it_op  <= op;
      it_ab  <= {pin_a, pin_b};
      it_now <= now_ms;
    end
    case (cmd.op)
      qpsm_pkg::CMD_EVAL: begin
        rq_go   <= go;
        rq_neg  <= use_encoder_feedback && pos_delta[PW-1];
        rq_zero <= mag_sel == '0;
        rq_sat  <= unit_zero;
        rq_mag  <= mag_sel;
        rq_dt   <= use_encoder_feedback ? dt_enc : dt_tach;
      end
      qpsm_pkg::CMD_MUL_NUM_SETUP: begin
        ma  <= rq_mag;
        mb  <= use_encoder_feedback ? qpsm_pkg::SCALE_ENC : qpsm_pkg::SCALE_TACH;
        pp  <= '0;
        acc <= '0;
      end
      qpsm_pkg::CMD_MUL_STEP: begin
        pp  <= ma_top * mb;
        ma  <= ma << CW;
        acc <= (acc << CW) + WW'(pp);
      end
      qpsm_pkg::CMD_MUL_DEN_SETUP: begin
        num <= acc;
        ma  <= MW'(rq_dt);
        mb  <= use_encoder_feedback ? unit_enc : 32'(fg_pulses_per_rev);
        pp  <= '0;
        acc <= '0;
      end
      qpsm_pkg::CMD_DIV_SETUP: begin
        den <= acc;
        ovf <= num_hi >= acc;
        rem <= num_hi;
        dq  <= num[QB-1:0];
      end
      qpsm_pkg::CMD_DIV_STEP: begin
        rem <= ge ? diff[WW-1:0] : rem2[WW-1:0];
        dq  <= {dq[QB-2:0], ge};
      end
      default: ;
    endcase
    if (out_load) begin
      position  <= pos64[31:0];
      rpm_q8    <= rpm_res;
      rpm_valid <= rq_go;
    end
  end

endmodule

FILE: sv/quadrature_position_speed_meter.sv
// Each input transaction passes through the EVAL, DECIDE and RESULT states; a
// speed request that is due and has nonzero magnitude and units also runs the
// 32x32 chunked multiplier (C = ceil(max(POSITION_WIDTH, TIME_WIDTH)/32) chunks)
// and the one-bit-per-cycle divider first. One transaction in flight; input is
// taken again the cycle after the result is loaded. Synchronous active-high reset
// idles the controller, restores configuration defaults, clears counters and out_valid.
module quadrature_position_speed_meter #(
  parameter int POSITION_WIDTH = 32,
  parameter int TIME_WIDTH     = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         op,
  input  logic               pin_a,
  input  logic               pin_b,
  input  logic [31:0]        now_ms,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] position,
  output logic signed [31:0] rpm_q8,
  output logic               rpm_valid
);

  localparam int MAX_W      = (POSITION_WIDTH > TIME_WIDTH) ? POSITION_WIDTH : TIME_WIDTH;
  localparam int MUL_CHUNKS = (MAX_W + qpsm_pkg::CHUNK_W - 1) / qpsm_pkg::CHUNK_W;

  qpsm_pkg::ctl_cmd_t   cmd;
  qpsm_pkg::dp_status_t st;

  qpsm_ctrl #(
    .MUL_CHUNKS (MUL_CHUNKS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  qpsm_datapath #(
    .POSITION_WIDTH (POSITION_WIDTH),
    .TIME_WIDTH     (TIME_WIDTH),
    .MUL_CHUNKS     (MUL_CHUNKS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .op        (op),
    .pin_a     (pin_a),
    .pin_b     (pin_b),
    .now_ms    (now_ms),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .position  (position),
    .rpm_q8    (rpm_q8),
    .rpm_valid (rpm_valid),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

FILE: dv/speed_meter_checker.sv
module speed_meter_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [2:0]         op,
  input  logic               pin_a,
  input  logic               pin_b,
  input  logic [31:0]        now_ms,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] position,
  input  logic signed [31:0] rpm_q8,
  input  logic               rpm_valid,
  output int                 mismatches,
  output int                 readings_due_count
);

  localparam int unsigned ENC_MIN_MS  = 10;
  localparam int unsigned TACH_MIN_MS = 50;
  localparam logic [63:0] ENC_SCALE   = 64'd60000 << 16;
  localparam logic [63:0] TACH_SCALE  = 64'd60000 << 8;

  typedef struct packed {
    logic signed [31:0] position;
    logic signed [31:0] rpm;
    logic               valid;
  } reading_t;

  reading_t readings_due[$];

  logic [15:0] ticks_cfg;
  logic [15:0] gear_cfg;
  logic [7:0]  fg_cfg;
  logic        enc_cfg;

  logic [1:0]  ab_last;
  logic [31:0] pos_count;
  logic [31:0] pos_mark;
  logic [31:0] enc_stamp;
  logic [31:0] tach_pulses;
  logic [31:0] tach_stamp;

  initial begin
    mismatches = 0;
    readings_due_count = 0;
  end

  task automatic report(input string what);
    if (mismatches < 200) begin
      $display("%0t: mismatch: %s", $time, what);
    end
    mismatches++;
  endtask

  // magnitude * scale / (dt * unit), truncated, signed, saturated to 32 bits
  function automatic logic [31:0] scaled_speed(input logic [63:0] mag, input logic neg,
                                               input logic [63:0] scale,
                                               input logic [63:0] dt,
                                               input logic [63:0] unit);
    logic [127:0] num;
    logic [127:0] den;
    logic [127:0] quo;
    logic [63:0]  lim;
    logic [63:0]  v;
    lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    if (mag == 64'd0) return 32'd0;
    if (unit == 64'd0) begin
      v = lim;
    end else begin
      num = {64'd0, mag} * {64'd0, scale};
      den = {64'd0, dt} * {64'd0, unit};
      quo = num / den;
      v = (quo > {64'd0, lim}) ? lim : quo[63:0];
    end
    if (neg) v = ~v + 64'd1;
    return v[31:0];
  endfunction

  function automatic reading_t meter_step(input logic [2:0] code, input logic [1:0] ab,
                                          input logic [31:0] t);
    reading_t    r;
    logic [31:0] dt;
    logic [31:0] delta;
    logic [31:0] mag;
    logic [63:0] enc_unit;
    r = '0;
    case (code)
      qpsm_pkg::OP_AB_CHANGE: begin
        case ({ab_last, ab})
          4'b0001, 4'b0111, 4'b1110, 4'b1000: pos_count = pos_count + 32'd1;
          4'b0010, 4'b1011, 4'b1101, 4'b0100: pos_count = pos_count - 32'd1;
          default: ;
        endcase
        ab_last = ab;
      end
      qpsm_pkg::OP_TACH_PULSE: tach_pulses = tach_pulses + 32'd1;
      qpsm_pkg::OP_SPEED_REQ: begin
        if (enc_cfg) begin
          dt = t - enc_stamp;
          if (dt >= ENC_MIN_MS) begin
            delta = pos_count - pos_mark;
            mag = delta[31] ? (~delta + 32'd1) : delta;
            enc_unit = {48'd0, ticks_cfg} * {48'd0, gear_cfg};
            r.rpm = scaled_speed({32'd0, mag}, delta[31], ENC_SCALE, {32'd0, dt}, enc_unit);
            r.valid = 1'b1;
            pos_mark = pos_count;
            enc_stamp = t;
          end
        end else begin
          dt = t - tach_stamp;
          if (dt >= TACH_MIN_MS) begin
            r.rpm = scaled_speed({32'd0, tach_pulses}, 1'b0, TACH_SCALE, {32'd0, dt},
                                 {56'd0, fg_cfg});
            r.valid = 1'b1;
            tach_pulses = '0;
            tach_stamp = t;
          end
        end
      end
      qpsm_pkg::OP_POS_RESET: begin
        pos_count = '0;
        pos_mark = '0;
      end
      qpsm_pkg::OP_START: begin
        ab_last = ab;
        pos_count = '0;
        pos_mark = '0;
        tach_pulses = '0;
        enc_stamp = t;
        tach_stamp = t;
      end
      default: ;
    endcase
    r.position = pos_count;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    reading_t want;
    if (rst) begin
      ticks_cfg = 16'd100;
      gear_cfg = 16'd256;
      fg_cfg = 8'd6;
      enc_cfg = 1'b1;
      ab_last = '0;
      pos_count = '0;
      pos_mark = '0;
      enc_stamp = '0;
      tach_pulses = '0;
      tach_stamp = '0;
      readings_due.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          qpsm_pkg::REG_TICKS_PER_REV: ticks_cfg = cfg_data;
          qpsm_pkg::REG_GEAR_RATIO:    gear_cfg = cfg_data;
          qpsm_pkg::REG_FG_PULSES:     fg_cfg = cfg_data[7:0];
          qpsm_pkg::REG_USE_ENCODER:   enc_cfg = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        readings_due.push_back(meter_step(op, {pin_a, pin_b}, now_ms));
      end
      if (out_valid && !out_stall) begin
        if (readings_due.size() == 0) begin
          report($sformatf("result with nothing pending, position %0d rpm %0d valid %0b",
                           position, rpm_q8, rpm_valid));
        end else begin
          want = readings_due.pop_front();
          if (position !== want.position)
            report($sformatf("position %0d, expected %0d", position, want.position));
          if (rpm_q8 !== want.rpm)
            report($sformatf("rpm_q8 %0d, expected %0d", rpm_q8, want.rpm));
          if (rpm_valid !== want.valid)
            report($sformatf("rpm_valid %0b, expected %0b", rpm_valid, want.valid));
        end
      end
    end
    readings_due_count <= readings_due.size();
  end

endmodule

FILE: dv/testbench.sv
module testbench;

  localparam int          ITEMS       = 1400;
  localparam int          HOLD_CYCLES = 300;
  localparam int unsigned ENC_MIN_MS  = 10;
  localparam int unsigned TACH_MIN_MS = 50;
  localparam int          OP_SPARE_LO = 5;
  localparam int          OP_SPARE_HI = 7;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [1:0]         cfg_index = qpsm_pkg::REG_TICKS_PER_REV;
  logic [15:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         op = qpsm_pkg::OP_AB_CHANGE;
  logic               pin_a = 1'b0;
  logic               pin_b = 1'b0;
  logic [31:0]        now_ms = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] position;
  logic signed [31:0] rpm_q8;
  logic               rpm_valid;
  int                 mismatches;
  int                 readings_due_count;

  int          sent = 0;
  int          holds_asked = 0;
  int          holds_done = 0;
  int          send_calm = 0;
  int          stall_calm = 0;
  logic [1:0]  ab_now = 2'b00;
  logic        enc_mode = 1'b1;
  logic [31:0] enc_mark = '0;
  logic [31:0] tach_mark = '0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  quadrature_position_speed_meter DUT (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .pin_a(pin_a), .pin_b(pin_b), .now_ms(now_ms),
    .out_valid(out_valid), .out_stall(out_stall),
    .position(position), .rpm_q8(rpm_q8), .rpm_valid(rpm_valid)
  );

  speed_meter_checker meter_check (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .pin_a(pin_a), .pin_b(pin_b), .now_ms(now_ms),
    .out_valid(out_valid), .out_stall(out_stall),
    .position(position), .rpm_q8(rpm_q8), .rpm_valid(rpm_valid),
    .mismatches(mismatches), .readings_due_count(readings_due_count)
  );

  // mostly short gaps, a few long ones, and now and then a calm stretch with none
  task automatic pick_gap(inout int calm, output int n);
    int r;
    r = $urandom_range(0, 99);
    if (calm > 0) begin
      calm--;
      n = 0;
    end else if (r < 3) begin
      calm = $urandom_range(20, 80);
      n = 0;
    end else if (r < 50) begin
      n = 0;
    end else if (r < 92) begin
      n = $urandom_range(1, 3);
    end else begin
      n = $urandom_range(8, 40);
    end
  endtask

  function automatic logic [1:0] gray_next(input logic [1:0] ab, input logic fwd);
    case (ab)
      2'b00:   return fwd ? 2'b01 : 2'b10;
      2'b01:   return fwd ? 2'b11 : 2'b00;
      2'b11:   return fwd ? 2'b10 : 2'b01;
      default: return fwd ? 2'b00 : 2'b11;
    endcase
  endfunction

  task automatic send(input logic [2:0] code, input logic [1:0] ab, input logic [31:0] t);
    int gap;
    op <= code;
    pin_a <= ab[1];
    pin_b <= ab[0];
    now_ms <= t;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sent++;
    if (code == qpsm_pkg::OP_AB_CHANGE || code == qpsm_pkg::OP_START) ab_now = ab;
    if (code == qpsm_pkg::OP_START) begin
      enc_mark = t;
      tach_mark = t;
    end
    if (code == qpsm_pkg::OP_SPEED_REQ) begin
      if (enc_mode && t - enc_mark >= ENC_MIN_MS) enc_mark = t;
      if (!enc_mode && t - tach_mark >= TACH_MIN_MS) tach_mark = t;
    end
    pick_gap(send_calm, gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle;
    in_valid <= 1'b0;
    do @(posedge clk); while (readings_due_count != 0);
  endtask

  task automatic put_reg(input qpsm_pkg::reg_idx_t idx, input logic [15:0] v);
    cfg_index <= idx;
    cfg_data <= v;
    cfg_write <= 1'b1;
    @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] ticks, input logic [15:0] gear,
                           input logic [15:0] fg_word, input logic [15:0] enc_word);
    settle;
    put_reg(qpsm_pkg::REG_TICKS_PER_REV, ticks);
    put_reg(qpsm_pkg::REG_GEAR_RATIO, gear);
    put_reg(qpsm_pkg::REG_FG_PULSES, fg_word);
    put_reg(qpsm_pkg::REG_USE_ENCODER, enc_word);
    cfg_write <= 1'b0;
    enc_mode = enc_word[0];
  endtask

  // receiver: random stalls, plus long hold-offs on request so the block backs up
  initial begin : receiver
    int left;
    left = 0;
    forever begin
      @(posedge clk);
      if (holds_done < holds_asked) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
        out_stall <= 1'b0;
        left = 0;
      end else if (left > 0) begin
        out_stall <= 1'b1;
        left--;
      end else begin
        out_stall <= 1'b0;
        pick_gap(stall_calm, left);
      end
    end
  end

  initial begin
    #8_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    int          phase;
    int          quota;
    int          steps;
    int          r;
    logic        dir;
    logic [31:0] thr;
    logic [31:0] base;
    logic [31:0] dtv;
    logic [15:0] ticks_w;
    logic [15:0] gear_w;
    logic [15:0] fg_w;
    logic [15:0] enc_w;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset defaults: steps both ways, a two-bit jump, an unchanged state
    send(qpsm_pkg::OP_AB_CHANGE, 2'b01, 32'd0);
    send(qpsm_pkg::OP_AB_CHANGE, 2'b11, 32'd0);
    send(qpsm_pkg::OP_AB_CHANGE, 2'b01, 32'd0);
    send(qpsm_pkg::OP_AB_CHANGE, 2'b10, 32'd0);
    send(qpsm_pkg::OP_AB_CHANGE, 2'b10, 32'd0);
    send(qpsm_pkg::OP_TACH_PULSE, 2'b00, 32'hFFFF_FFFF);
    send(qpsm_pkg::OP_SPEED_REQ, 2'b11, 32'd9);
    send(qpsm_pkg::OP_SPEED_REQ, 2'b00, 32'd10);
    send(qpsm_pkg::OP_POS_RESET, 2'b11, 32'hAAAA_5555);
    for (int c = OP_SPARE_LO; c <= OP_SPARE_HI; c++) send(3'(c), 2'($urandom), $urandom);

    // negative saturation across a timestamp wrap
    configure(16'd1, 16'd1, 16'd0, 16'd1);
    send(qpsm_pkg::OP_START, 2'b11, 32'hFFFF_FFF8);
    repeat (6) send(qpsm_pkg::OP_AB_CHANGE, gray_next(ab_now, 1'b0), 32'h5555_AAAA);
    send(qpsm_pkg::OP_SPEED_REQ, 2'b00, 32'd2);

    // tachometer with zero pulses per revolution, short and exact-minimum intervals
    configure(16'd0, 16'd256, 16'd0, 16'd0);
    send(qpsm_pkg::OP_TACH_PULSE, 2'b01, 32'd0);
    send(qpsm_pkg::OP_SPEED_REQ, 2'b10, tach_mark + 32'd49);
    send(qpsm_pkg::OP_SPEED_REQ, 2'b01, tach_mark + 32'd50);

    phase = 0;
    while (sent < ITEMS) begin
      case (phase)
        0: configure(16'hFFFF, 16'hFFFF, 16'h00FF, 16'h0001);
        1: configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFE);
        2: configure(16'h0001, 16'h0001, 16'h0001, 16'h0001);
        3: configure(16'h0001, 16'h0001, 16'hFF01, 16'h0000);
        default: begin
          r = $urandom_range(0, 9);
          ticks_w = (r == 0) ? 16'd0 : (r == 1) ? 16'd1 : (r == 2) ? 16'hFFFF :
                    (r == 3) ? 16'($urandom) : 16'($urandom_range(1, 400));
          r = $urandom_range(0, 9);
          gear_w = (r == 0) ? 16'd0 : (r == 1) ? 16'd1 : (r == 2) ? 16'hFFFF :
                   (r == 3) ? 16'($urandom) : 16'($urandom_range(64, 1024));
          r = $urandom_range(0, 9);
          fg_w = {8'($urandom), (r == 0) ? 8'd0 : (r == 1) ? 8'd1 : (r == 2) ? 8'hFF :
                  8'($urandom_range(1, 64))};
          enc_w = {15'($urandom), 1'($urandom)};
          configure(ticks_w, gear_w, fg_w, enc_w);
        end
      endcase
      quota = sent + $urandom_range(80, 140);
      while (sent < quota) begin
        if ((holds_asked == 0 && sent >= 400) || (holds_asked == 1 && sent >= 1000))
          holds_asked++;
        if ($urandom_range(0, 99) < 75) begin
          // well-formed run: optional start, a quadrature walk with pulses, an occasional position reset, a request
          if ($urandom_range(0, 99) < 12)
            send(qpsm_pkg::OP_START, 2'($urandom),
                 $urandom_range(0, 1) ? $urandom : enc_mark + $urandom_range(0, 500));
          steps = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                              : $urandom_range(0, 12);
          dir = 1'($urandom);
          for (int i = 0; i < steps; i++) begin
            if ($urandom_range(0, 9) == 0) dir = !dir;
            send(qpsm_pkg::OP_AB_CHANGE, gray_next(ab_now, dir), $urandom);
            if ($urandom_range(0, 99) < (enc_mode ? 15 : 60))
              send(qpsm_pkg::OP_TACH_PULSE, 2'($urandom), $urandom);
          end
          if ($urandom_range(0, 19) == 0)
            send(qpsm_pkg::OP_POS_RESET, 2'($urandom), $urandom);
          thr = enc_mode ? ENC_MIN_MS : TACH_MIN_MS;
          base = enc_mode ? enc_mark : tach_mark;
          r = $urandom_range(0, 99);
          if (r < 12) dtv = $urandom_range(0, thr - 1);
          else if (r < 27) dtv = thr - 1 + $urandom_range(0, 2);
          else if (r < 90) dtv = $urandom_range(thr, 3000);
          else dtv = $urandom;
          send(qpsm_pkg::OP_SPEED_REQ, 2'($urandom), base + dtv);
        end else begin
          repeat ($urandom_range(1, 5)) send(3'($urandom), 2'($urandom), $urandom);
        end
      end
      phase++;
    end

    settle;
    repeat (60) @(posedge clk);
    if (mismatches == 0 && readings_due_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/qpsm_pkg.sv
sv/qpsm_ctrl.sv
sv/qpsm_datapath.sv
sv/quadrature_position_speed_meter.sv
dv/speed_meter_checker.sv
dv/testbench.sv
